// ----- rtl/core/rplsh_pkg.sv -----
// ----------------------------------------------------------------------------
// Random projection LSH hasher package
// Shared widths, transaction payloads and the packet that travels the cell row.
// ----------------------------------------------------------------------------
package rplsh_pkg;

   localparam int unsigned NUM_HASH_DEFAULT  = 16;
   localparam int unsigned EMBED_DIM_DEFAULT = 256;

   localparam int unsigned MAX_ROWS = 16;
   localparam int unsigned MAX_COLS = 256;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned ROW_W    = 4;
   localparam int unsigned COL_W    = 8;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned KEY_W    = 16;
   localparam int unsigned LEN_W    = 9;

   localparam int unsigned PROD_W       = 2 * SAMPLE_W;
   localparam int unsigned ACC_W        = 48;
   localparam int unsigned SUM_W        = ACC_W + 1;
   localparam int unsigned FRAC_BITS    = 27;
   localparam int unsigned OFFSET_ALIGN = 15;
   localparam int unsigned QUO_W        = SUM_W - FRAC_BITS;
   localparam int unsigned MAG_W        = QUO_W + 1;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

   localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFFSET  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [ROW_W-1:0]           row;
      logic [COL_W-1:0]           column;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [OFFSET_W-1:0]        offset_value;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0] hash_key;
   } rsp_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0] vector_length;
   } csr_payload_type;

   // Transaction as it moves from cell to cell, one cell per cycle while the row advances.
   typedef struct packed {
      logic                valid;
      logic                elem;
      logic                last;
      logic [KIND_W-1:0]   kind;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    column;
      logic [SAMPLE_W-1:0] sample;
      logic [OFFSET_W-1:0] offset;
      logic [COL_W-1:0]    index;
   } cell_pkt_type;

   // Partial key, collected one row bit per cell.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } key_link_type;

endpackage

// ----- rtl/core/rplsh_chan_if.sv -----
// ----------------------------------------------------------------------------
// Random projection LSH hasher channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rplsh_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/random_projection_lsh_hasher.sv -----
// ----------------------------------------------------------------------------
// Random projection LSH hasher
// Hashes streamed embedding vectors into bucket keys, one hash row per cell.
// ----------------------------------------------------------------------------
// req_link carries one transaction per cycle while ready is high: weight loads,
// offset loads and embedding elements. Loads fill each row's weight column
// memory and offset. Elements are multiplied by every row's weight at the
// current position and added to that row's 48-bit saturating accumulator; on
// the last element of a vector each row quantizes its sum into one key bit and
// rsp_link delivers the packed hash_key. csr_link writes vector_length at any
// time it is valid. A transaction enters the first cell and moves one cell per
// cycle while the row advances; each cell has a seven-stage pipeline
// (memory read, multiply, accumulate, offset add, sign fold, reciprocal
// multiply, key merge), and each cell ORs its key bit into the key passed on
// from the cell before (rows capped at 16). Reset clears the accumulators, the
// element count and the output, and sets vector_length to 256; weights and
// offsets must be loaded before use. When rsp_link stalls with a key waiting
// and another key reaches the end of the row, the whole row holds and
// req_link drops ready until the waiting key is taken.
// ----------------------------------------------------------------------------
module random_projection_lsh_hasher #(
   parameter int unsigned NUM_HASH  = rplsh_pkg::NUM_HASH_DEFAULT,
   parameter int unsigned EMBED_DIM = rplsh_pkg::EMBED_DIM_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rplsh_chan_if.sink   req_link,
   rplsh_chan_if.source rsp_link,
   rplsh_chan_if.sink   csr_link
);

   localparam int unsigned ROWS = (NUM_HASH < rplsh_pkg::MAX_ROWS) ? NUM_HASH : rplsh_pkg::MAX_ROWS;
   localparam int unsigned COLS = (EMBED_DIM < rplsh_pkg::MAX_COLS) ? EMBED_DIM : rplsh_pkg::MAX_COLS;
   localparam logic [rplsh_pkg::LEN_W-1:0] LenCap = rplsh_pkg::LEN_W'(COLS);

   logic                          advance;
   logic                          req_accept;
   logic                          elem_accept;
   logic [rplsh_pkg::LEN_W-1:0]   vlen_ff;
   logic [rplsh_pkg::LEN_W-1:0]   eff_len;
   logic [rplsh_pkg::COL_W-1:0]   count_ff;
   logic [rplsh_pkg::LEN_W-1:0]   count_next;
   logic                          last_elem;
   logic                          rsp_valid_ff;
   logic [rplsh_pkg::KEY_W-1:0]   rsp_key_ff;
   rplsh_pkg::req_payload_type    req_data;
   rplsh_pkg::csr_payload_type    csr_data;
   rplsh_pkg::rsp_payload_type    rsp_data;
   rplsh_pkg::cell_pkt_type       head_pkt;
   rplsh_pkg::cell_pkt_type       pkt_chain [ROWS+1];
   rplsh_pkg::key_link_type       key_chain [ROWS+1];

   assign req_data = req_link.payload;
   assign csr_data = csr_link.payload;

   // Hold the whole row only when a new key would overrun a waiting one.
   assign advance = !(rsp_valid_ff && !rsp_link.ready && key_chain[ROWS].valid);

   assign req_link.ready = advance;
   assign csr_link.ready = 1'b1;

   assign req_accept  = req_link.valid && advance;
   assign elem_accept = req_accept && (req_data.kind == rplsh_pkg::KIND_ELEMENT);

   always_comb begin
      if (vlen_ff == '0) begin
         eff_len = rplsh_pkg::LEN_W'(1);
      end else if (vlen_ff > LenCap) begin
         eff_len = LenCap;
      end else begin
         eff_len = vlen_ff;
      end
   end

   assign count_next = {1'b0, count_ff} + rplsh_pkg::LEN_W'(1);
   assign last_elem  = count_next >= eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= rplsh_pkg::LEN_RESET;
      end else if (csr_link.valid) begin
         vlen_ff <= csr_data.vector_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (elem_accept) begin
         count_ff <= last_elem ? '0 : count_next[rplsh_pkg::COL_W-1:0];
      end
   end

   always_comb begin
      head_pkt.valid  = req_accept;
      head_pkt.elem   = elem_accept;
      head_pkt.last   = last_elem;
      head_pkt.kind   = req_data.kind;
      head_pkt.row    = req_data.row;
      head_pkt.column = req_data.column;
      head_pkt.sample = req_data.sample_value;
      head_pkt.offset = req_data.offset_value;
      head_pkt.index  = count_ff;
   end

   assign pkt_chain[0] = head_pkt;
   assign key_chain[0] = '0;

   for (genvar gi = 0; gi < ROWS; gi++) begin : g_cell
      rplsh_cell #(
         .ROW_ID   (gi),
         .COLS     (COLS),
         .NUM_HASH (NUM_HASH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pkt_in  (pkt_chain[gi]),
         .pkt_out (pkt_chain[gi+1]),
         .key_in  (key_chain[gi]),
         .key_out (key_chain[gi+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && key_chain[ROWS].valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_link.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && key_chain[ROWS].valid) begin
         rsp_key_ff <= key_chain[ROWS].key;
      end
   end

   assign rsp_data.hash_key = rsp_key_ff;
   assign rsp_link.valid    = rsp_valid_ff;
   assign rsp_link.payload  = rsp_data;

endmodule

// ----- rtl/core/rplsh_cell.sv -----
// ----------------------------------------------------------------------------
// Random projection LSH hash cell
// One hash row: weight column memory, offset, saturating MAC and key bit.
// ----------------------------------------------------------------------------
module rplsh_cell #(
   parameter int unsigned ROW_ID   = 0,
   parameter int unsigned COLS     = rplsh_pkg::EMBED_DIM_DEFAULT,
   parameter int unsigned NUM_HASH = rplsh_pkg::NUM_HASH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  rplsh_pkg::cell_pkt_type pkt_in,
   output rplsh_pkg::cell_pkt_type pkt_out,
   input  rplsh_pkg::key_link_type key_in,
   output rplsh_pkg::key_link_type key_out
);

   localparam int unsigned COL_AW  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int unsigned DIV_L   = $clog2(NUM_HASH);
   localparam int unsigned DIV_S   = rplsh_pkg::MAG_W + DIV_L;
   localparam int unsigned RECIP_W = rplsh_pkg::MAG_W + 2;
   localparam int unsigned MUL_W   = rplsh_pkg::MAG_W + RECIP_W;

   localparam logic [rplsh_pkg::COL_W:0] ColLimit = (rplsh_pkg::COL_W + 1)'(COLS);
   localparam logic [rplsh_pkg::ROW_W-1:0] RowCode = rplsh_pkg::ROW_W'(ROW_ID);
   localparam logic [RECIP_W-1:0] Recip =
      RECIP_W'(((64'd1 << DIV_S) + 64'(NUM_HASH) - 64'd1) / 64'(NUM_HASH));
   localparam logic [rplsh_pkg::MAG_W-1:0] Bias = rplsh_pkg::MAG_W'(NUM_HASH - 1);
   localparam logic signed [rplsh_pkg::ACC_W-1:0] AccMax = {1'b0, {(rplsh_pkg::ACC_W-1){1'b1}}};
   localparam logic signed [rplsh_pkg::ACC_W-1:0] AccMin = {1'b1, {(rplsh_pkg::ACC_W-1){1'b0}}};

   // stage 0: memory and offset
   logic [rplsh_pkg::SAMPLE_W-1:0] weight_mem [COLS];
   logic                            weight_we;
   logic                            offset_we;
   logic [rplsh_pkg::OFFSET_W-1:0]  offset_ff;

   // stage 1
   rplsh_pkg::cell_pkt_type         pkt_ff;
   logic [rplsh_pkg::SAMPLE_W-1:0]  weight_ff;
   logic [rplsh_pkg::OFFSET_W-1:0]  off1_ff;
   logic signed [rplsh_pkg::PROD_W-1:0] prod_in;

   // stage 2
   logic signed [rplsh_pkg::PROD_W-1:0] prod2_ff;
   logic                            elem2_ff;
   logic                            last2_ff;
   logic [rplsh_pkg::OFFSET_W-1:0]  off2_ff;
   logic signed [rplsh_pkg::ACC_W-1:0] acc_ff;
   logic signed [rplsh_pkg::SUM_W-1:0] acc_sum;
   logic signed [rplsh_pkg::ACC_W-1:0] acc_in;

   // stage 3
   logic signed [rplsh_pkg::ACC_W-1:0] fin3_ff;
   logic                            fire3_ff;
   logic [rplsh_pkg::OFFSET_W-1:0]  off3_ff;
   logic signed [rplsh_pkg::SUM_W-1:0] sum_in;

   // stage 4
   logic [rplsh_pkg::QUO_W-1:0]     quo4_ff;
   logic                            fire4_ff;
   logic [rplsh_pkg::MAG_W-1:0]     quo_ext;
   logic [rplsh_pkg::MAG_W-1:0]     mag_in;

   // stage 5
   logic [rplsh_pkg::MAG_W-1:0]     mag5_ff;
   logic                            fire5_ff;
   logic [MUL_W-1:0]                mul_in;

   // stage 6
   logic                            par6_ff;
   logic                            fire6_ff;
   rplsh_pkg::key_link_type         key_ff;
   logic [rplsh_pkg::KEY_W-1:0]     row_bit;

   assign weight_we = pkt_in.valid && (pkt_in.kind == rplsh_pkg::KIND_WEIGHT) &&
                      (pkt_in.row == RowCode) && ({1'b0, pkt_in.column} < ColLimit);
   assign offset_we = pkt_in.valid && (pkt_in.kind == rplsh_pkg::KIND_OFFSET) &&
                      (pkt_in.row == RowCode);

   always_ff @(posedge clock) begin
      if (advance) begin
         if (weight_we) begin
            weight_mem[pkt_in.column[COL_AW-1:0]] <= pkt_in.sample;
         end
         weight_ff <= weight_mem[pkt_in.index[COL_AW-1:0]];
      end
   end

   // Snapshot the offset as the element passes, so later offset loads cannot leak in.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (offset_we) begin
            offset_ff <= pkt_in.offset;
         end
         off1_ff <= offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.valid <= 1'b0;
         pkt_ff.elem  <= 1'b0;
         pkt_ff.last  <= 1'b0;
      end else if (advance) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_out = pkt_ff;

   assign prod_in = $signed(pkt_ff.sample) * $signed(weight_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         elem2_ff <= 1'b0;
         last2_ff <= 1'b0;
      end else if (advance) begin
         elem2_ff <= pkt_ff.elem;
         last2_ff <= pkt_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod2_ff <= prod_in;
         off2_ff  <= off1_ff;
      end
   end

   // saturating accumulate
   always_comb begin
      acc_sum = {acc_ff[rplsh_pkg::ACC_W-1], acc_ff} + rplsh_pkg::SUM_W'(prod2_ff);
      if (acc_sum[rplsh_pkg::SUM_W-1] != acc_sum[rplsh_pkg::ACC_W-1]) begin
         acc_in = acc_sum[rplsh_pkg::SUM_W-1] ? AccMin : AccMax;
      end else begin
         acc_in = acc_sum[rplsh_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         fire3_ff <= 1'b0;
      end else if (advance) begin
         fire3_ff <= elem2_ff && last2_ff;
         if (elem2_ff) begin
            acc_ff <= last2_ff ? '0 : acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin3_ff <= acc_in;
         off3_ff <= off2_ff;
      end
   end

   // add the aligned offset and drop the fraction bits (floor)
   assign sum_in = {fin3_ff[rplsh_pkg::ACC_W-1], fin3_ff} +
                   rplsh_pkg::SUM_W'({off3_ff, {rplsh_pkg::OFFSET_ALIGN{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         fire4_ff <= 1'b0;
         fire5_ff <= 1'b0;
         fire6_ff <= 1'b0;
      end else if (advance) begin
         fire4_ff <= fire3_ff;
         fire5_ff <= fire4_ff;
         fire6_ff <= fire5_ff;
      end
   end

   // floor(x / N) for negative x has the parity of (-x + N - 1) / N
   always_comb begin
      quo_ext = {quo4_ff[rplsh_pkg::QUO_W-1], quo4_ff};
      if (quo4_ff[rplsh_pkg::QUO_W-1]) begin
         mag_in = (~quo_ext + 1'b1) + Bias;
      end else begin
         mag_in = quo_ext;
      end
   end

   // divide by NUM_HASH through the reciprocal, exact for MAG_W-bit values
   assign mul_in = mag5_ff * Recip;

   always_ff @(posedge clock) begin
      if (advance) begin
         quo4_ff <= sum_in[rplsh_pkg::SUM_W-1:rplsh_pkg::FRAC_BITS];
         mag5_ff <= mag_in;
         par6_ff <= mul_in[DIV_S];
      end
   end

   assign row_bit = rplsh_pkg::KEY_W'({15'd0, par6_ff}) << ROW_ID;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.valid <= 1'b0;
      end else if (advance) begin
         key_ff.valid <= fire6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff.key <= key_in.key | row_bit;
      end
   end

   assign key_out = key_ff;

endmodule

// ----- bench/random_projection_lsh_hasher_tb.sv -----
// ----------------------------------------------------------------------------
// Random projection LSH hasher testbench
// Loads all row offsets and the weight columns that the vectors reach, then
// streams embedding elements under several vector lengths. A built-in
// projection model predicts every hash key, and each key on rsp_link is
// compared with the oldest prediction. Both sides idle at random, and the key
// receiver stalls once for a long stretch so that the block backs up into
// req_link.
// ----------------------------------------------------------------------------
module random_projection_lsh_hasher_tb;
   import rplsh_pkg::*;

   localparam int unsigned HASH_ROWS      = NUM_HASH_DEFAULT;
   localparam int unsigned EMBED_COLS     = EMBED_DIM_DEFAULT;
   localparam int unsigned FILL_COLS      = 32;
   localparam int          SETTLE_CYCLES  = 40;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          WATCHDOG_LIMIT = 3000;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rplsh_chan_if #(.payload_type(req_payload_type)) req_link ();
   rplsh_chan_if #(.payload_type(rsp_payload_type)) rsp_link ();
   rplsh_chan_if #(.payload_type(csr_payload_type)) csr_link ();

   random_projection_lsh_hasher dut (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .rsp_link (rsp_link),
      .csr_link (csr_link)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Projection model state
   logic signed [SAMPLE_W-1:0] weight_table [HASH_ROWS][EMBED_COLS];
   logic [OFFSET_W-1:0]        row_offset   [HASH_ROWS];
   longint                     row_acc      [HASH_ROWS];
   int                         elem_count;
   logic [LEN_W-1:0]           model_len;

   req_payload_type  request_queue [$];
   logic [KEY_W-1:0] pending_keys  [$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;
   logic hold_off  = 1'b0;
   logic pressure_arm = 1'b0;

   int items_queued    = 0;
   int items_accepted  = 0;
   int loads_accepted  = 0;
   int keys_checked    = 0;
   int length_writes   = 0;
   int fail_count      = 0;
   int stall_cycles    = 0;
   int pressure_from   = 0;
   int send_gap        = 0;
   int send_calm       = 0;
   int recv_gap        = 0;
   int recv_calm       = 0;
   logic [KEY_W-1:0] want_key;

   function automatic int draw_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the projection model by one accepted transaction.
   function automatic void project_and_hash(req_payload_type it);
      longint           prod;
      longint           sum;
      longint           quo;
      longint           divisor;
      int               limit;
      logic [KEY_W-1:0] key;
      case (it.kind)
         KIND_WEIGHT: begin
            weight_table[it.row][it.column] = it.sample_value;
            loads_accepted++;
         end
         KIND_OFFSET: begin
            row_offset[it.row] = it.offset_value;
            loads_accepted++;
         end
         KIND_ELEMENT: begin
            for (int r = 0; r < HASH_ROWS; r++) begin
               prod = longint'($signed(it.sample_value)) *
                      longint'($signed(weight_table[r][elem_count]));
               sum = row_acc[r] + prod;
               // saturate to the 48-bit accumulator range
               if (sum > (64'sd1 <<< 47) - 1) sum = (64'sd1 <<< 47) - 1;
               if (sum < -(64'sd1 <<< 47)) sum = -(64'sd1 <<< 47);
               row_acc[r] = sum;
            end
            limit = (model_len == 0) ? 1 : int'(model_len);
            if (limit > EMBED_COLS) limit = EMBED_COLS;
            if (elem_count + 1 >= limit) begin
               key = '0;
               divisor = longint'(HASH_ROWS) <<< FRAC_BITS;
               for (int r = 0; r < HASH_ROWS; r++) begin
                  sum = row_acc[r] + (longint'(row_offset[r]) <<< OFFSET_ALIGN);
                  quo = sum / divisor;
                  // round toward minus infinity
                  if (sum % divisor != 0 && sum < 0) quo = quo - 1;
                  key[r] = quo[0];
                  row_acc[r] = 0;
               end
               pending_keys = {pending_keys, key};
               elem_count = 0;
            end else begin
               elem_count = (elem_count + 1) % EMBED_COLS;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_payload_type make_request(logic [KIND_W-1:0] kind,
                                                    logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] column,
                                                    logic [SAMPLE_W-1:0] sample,
                                                    logic [OFFSET_W-1:0] offs);
      req_payload_type it;
      it.kind         = kind;
      it.row          = row;
      it.column       = column;
      it.sample_value = sample;
      it.offset_value = offs;
      return it;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'h8000;
      if (roll == 1) return 16'h7FFF;
      return SAMPLE_W'($urandom());
   endfunction

   function automatic req_payload_type random_request();
      int               roll;
      logic [KIND_W-1:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 72)      kind = KIND_ELEMENT;
      else if (roll < 84) kind = KIND_WEIGHT;
      else if (roll < 94) kind = KIND_OFFSET;
      else                kind = KIND_UNUSED;
      return make_request(kind, ROW_W'($urandom()), COL_W'($urandom()),
                          random_sample(), OFFSET_W'($urandom()));
   endfunction

   // Callers enqueue only after a rising edge, away from the driver's falling edge.
   task automatic queue_item(req_payload_type it);
      request_queue = {request_queue, it};
      items_queued++;
   endtask

   task automatic drain_and_settle();
      while (items_accepted != items_queued || pending_keys.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] len);
      @(negedge clock);
      csr_link.valid                 <= 1'b1;
      csr_link.payload.vector_length <= len;
      do @(negedge clock); while (!csr_taken);
      csr_link.valid <= 1'b0;
      length_writes++;
   endtask

   task automatic random_phase(logic [LEN_W-1:0] len, int count);
      drain_and_settle();
      write_length(len);
      @(posedge clock);
      repeat (count) queue_item(random_request());
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_link.valid <= 1'b0;
      end else if (!req_link.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_link.valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            req_link.payload <= request_queue.pop_front();
            req_link.valid   <= 1'b1;
            send_gap = draw_gap(send_calm);
         end else begin
            req_link.valid <= 1'b0;
         end
      end
   end

   // Key receiver: pick a fresh gap after every taken key
   always @(negedge clock) begin
      if (recv_gap > 0) recv_gap--;
      else if (rsp_taken) recv_gap = draw_gap(recv_calm);
      rsp_link.ready <= !hold_off && recv_gap == 0;
   end

   // Monitor, model update and key check
   always @(posedge clock) begin
      req_taken <= !reset && req_link.valid && req_link.ready;
      rsp_taken <= !reset && rsp_link.valid && rsp_link.ready;
      csr_taken <= !reset && csr_link.valid && csr_link.ready;
      if (reset) begin
         foreach (row_acc[r]) row_acc[r] = 0;
         elem_count   = 0;
         model_len    = LEN_RESET;
         stall_cycles = 0;
      end else begin
         if (req_link.valid && req_link.ready) begin
            project_and_hash(req_link.payload);
            items_accepted++;
         end
         if (csr_link.valid && csr_link.ready)
            model_len = csr_link.payload.vector_length;
         if (rsp_link.valid && rsp_link.ready) begin
            if (pending_keys.size() == 0) begin
               $error("hash_key: unexpected transaction, actual %h",
                      rsp_link.payload.hash_key);
               fail_count++;
            end else begin
               want_key = pending_keys.pop_front();
               if (rsp_link.payload.hash_key !== want_key) begin
                  $error("hash_key mismatch: expected %h, actual %h",
                         want_key, rsp_link.payload.hash_key);
                  fail_count++;
               end
               keys_checked++;
            end
         end
         if ((req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready) ||
             (csr_link.valid && csr_link.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // Long receiver hold-off once keys are flowing at one per element
   initial begin
      wait (pressure_arm);
      wait (keys_checked >= pressure_from);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_link.valid   = 1'b0;
      req_link.payload = '0;
      rsp_link.ready   = 1'b0;
      csr_link.valid   = 1'b0;
      csr_link.payload = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      write_length(LEN_W'(4));

      // Fill every offset and the weight columns the vectors reach before any element.
      @(posedge clock);
      for (int r = 0; r < HASH_ROWS; r++)
         queue_item(make_request(KIND_OFFSET, ROW_W'(r), COL_W'($urandom()),
                                 random_sample(),
                                 (r == 0) ? 16'h0000 :
                                 (r == HASH_ROWS - 1) ? 16'hFFFF : OFFSET_W'($urandom())));
      for (int r = 0; r < HASH_ROWS; r++)
         for (int c = 0; c < FILL_COLS; c++)
            queue_item(make_request(KIND_WEIGHT, ROW_W'(r), COL_W'(c), random_sample(),
                                    OFFSET_W'($urandom())));

      // Directed: extreme elements, an ignored kind, loads inside a vector.
      @(posedge clock);
      queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, 16'h8000, 16'h0000));
      queue_item(make_request(KIND_ELEMENT, 4'hF, 8'hFF, 16'h7FFF, 16'hFFFF));
      queue_item(make_request(KIND_UNUSED, 4'h5, 8'hA5, 16'h7FFF, 16'h1234));
      queue_item(make_request(KIND_OFFSET, 4'h3, 8'h00, 16'h0000, 16'hFFFF));
      queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, 16'h0000, 16'h0000));
      queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, 16'hFFFF, 16'h0000));
      queue_item(make_request(KIND_WEIGHT, 4'hF, 8'h01, 16'h8000, 16'h0000));
      queue_item(make_request(KIND_WEIGHT, 4'h0, 8'hFF, 16'h7FFF, 16'h0000));
      repeat (4) queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, 16'h7FFF, 16'h0000));
      drain_and_settle();

      // Shorten the length under a partly filled vector.
      write_length(LEN_W'(8));
      @(posedge clock);
      repeat (5) queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, random_sample(), 16'h0));
      drain_and_settle();
      write_length(LEN_W'(3));
      @(posedge clock);
      queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, 16'h8000, 16'h0000));
      drain_and_settle();

      // Length zero behaves as one; an oversized length is capped.
      write_length(LEN_W'(0));
      @(posedge clock);
      repeat (2) queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, random_sample(), 16'h0));
      drain_and_settle();
      write_length(LEN_W'(511));
      @(posedge clock);
      repeat (3) queue_item(make_request(KIND_ELEMENT, 4'h0, 8'h00, random_sample(), 16'h0));

      // Random traffic; the length-one phase carries the long receiver stall.
      random_phase(LEN_W'(1), 150);
      pressure_from = keys_checked + 5;
      pressure_arm  = 1'b1;
      random_phase(LEN_W'(2), 100);
      random_phase(LEN_W'(5), 100);
      random_phase(LEN_W'(16), 100);
      random_phase(LEN_W'(FILL_COLS), 100);
      random_phase(LEN_W'($urandom_range(1, FILL_COLS)), 60);
      random_phase(LEN_W'(3), 40);

      drain_and_settle();
      if (pending_keys.size() != 0) begin
         $error("hash_key: %0d expected keys never arrived", pending_keys.size());
         fail_count++;
      end
      $display("Covered %0d requests (%0d table loads) and %0d checked hash keys",
               items_accepted, loads_accepted, keys_checked);
      $display("across %0d vector length settings, with one long receiver stall",
               length_writes);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- random_projection_lsh_hasher.f -----
rtl/core/rplsh_pkg.sv
rtl/core/rplsh_chan_if.sv
rtl/core/rplsh_cell.sv
rtl/core/random_projection_lsh_hasher.sv
bench/random_projection_lsh_hasher_tb.sv
